FILE: sv/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

    // Fixed field and register widths, default pattern length and queue depth
    localparam int CNT_W       = 32;
    localparam int PAT_BYTES   = 32;
    localparam int MASK_W      = 32;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int FIFO_DEPTH  = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH = 3'd0,
        REG_WORD0  = 3'd1,
        REG_WORD1  = 3'd2,
        REG_WORD2  = 3'd3,
        REG_WORD3  = 3'd4,
        REG_MASK   = 3'd5,
        REG_MODE   = 3'd6
    } cfg_reg_t;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic ST_MATCH = 1'b0;
    localparam logic ST_MISS  = 1'b1;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        logic             is_answer;
        logic             status;
        logic [CNT_W-1:0] offset;
        logic             last;
    } step_t;

endpackage

`default_nettype wire

FILE: sv/mbps_front.sv
`default_nettype none

module mbps_front #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       in_byte,
    input  wire logic                             in_last,
    input  wire logic [mbps_pkg::LEN_W-1:0]       pattern_length,
    input  wire logic [MAX_PATTERN-1:0][7:0]      pattern,
    input  wire logic [MAX_PATTERN-1:0]           care,
    input  wire logic                             mode,
    output logic                                  push,
    output mbps_pkg::step_t                       push_step,
    input  wire logic                             q_full
);
    import mbps_pkg::*;

    localparam int N_W   = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][7:0] win_reg, win_next;
    logic [CNT_W-1:0]            seen_reg, seen_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        stage_valid_reg, stage_valid_next;
    logic                        last_reg;
    logic                        mode_reg;
    logic [N_W-1:0]              n_reg, n_next;
    logic                        accept;
    logic                        match;
    logic [IDX_W-1:0]            jj;

    // Clamp the length into 1..MAX_PATTERN
    always_comb
    begin
        if (pattern_length == '0)
            n_next = N_W'(1);
        else if (int'(pattern_length) > MAX_PATTERN)
            n_next = N_W'(MAX_PATTERN);
        else
            n_next = N_W'(pattern_length);
    end

    assign push     = stage_valid_reg && !q_full;
    assign in_ready = !stage_valid_reg || push;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        win_next[0] = in_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
            win_next[i] = win_reg[i-1];
    end

    always_comb
    begin
        count_next = (seen_reg == '1) ? seen_reg : seen_reg + CNT_W'(1);
        seen_next  = in_last ? '0 : count_next;
        stage_valid_next = accept ? 1'b1 : (push ? 1'b0 : stage_valid_reg);
    end

    // Pattern byte j lines up with window slot n-1-j
    always_comb
    begin
        match = 1'b1;
        jj    = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < int'(n_reg))
            begin
                jj = IDX_W'(int'(n_reg) - 1 - i);
                if (care[jj] && (win_reg[i] != pattern[jj]))
                    match = 1'b0;
            end
        end
    end

    always_comb
    begin
        push_step.last   = last_reg;
        push_step.offset = count_reg - CNT_W'(n_reg);
        if (mode_reg == MODE_CHECK)
        begin
            push_step.is_answer = (count_reg == CNT_W'(n_reg));
            push_step.status    = match ? ST_MATCH : ST_MISS;
            push_step.offset    = '0;
        end
        else
        begin
            push_step.is_answer = (count_reg >= CNT_W'(n_reg)) && match;
            push_step.status    = ST_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
                seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
            last_reg  <= in_last;
            mode_reg  <= mode;
            n_reg     <= n_next;
        end
    end

`ifndef SYNTHESIS
    // A region's end clears the byte count for the next region
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> seen_reg == '0)
        else $error("byte count not cleared after region end");
`endif

endmodule

`default_nettype wire

FILE: sv/mbps_fifo.sv
`default_nettype none

module mbps_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mbps_pkg::step_t push_step,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output mbps_pkg::step_t      head
);
    import mbps_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_Q = $clog2(FIFO_DEPTH + 1);

    step_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_Q-1:0]  fill_reg, fill_next;

    assign full      = (fill_reg == CNT_Q'(FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + CNT_Q'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_Q'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0
                              : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_step;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !not_empty))
        else $error("queue overrun or underrun");
`endif

endmodule

`default_nettype wire

FILE: sv/mbps_back.sv
`default_nettype none

module mbps_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire mbps_pkg::step_t             q_head,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_status,
    output logic [mbps_pkg::CNT_W-1:0]       out_offset
);
    import mbps_pkg::*;

    logic             answered_reg, answered_next;
    logic             out_valid_reg, out_valid_next;
    logic             status_reg;
    logic [CNT_W-1:0] offset_reg;
    logic             produce;

    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign produce = pop && !answered_reg && (q_head.is_answer || q_head.last);

    always_comb
    begin
        answered_next = answered_reg;
        if (pop)
            answered_next = q_head.last ? 1'b0 : (answered_reg || produce);
        out_valid_next = produce ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answered_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            answered_reg  <= answered_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            status_reg <= q_head.is_answer ? q_head.status : ST_MISS;
            offset_reg <= q_head.is_answer ? q_head.offset : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_offset = offset_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_head.last |=> !answered_reg)
        else $error("answer flag not cleared at region end");

    assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> out_valid_reg)
        else $error("result not loaded into output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && answered_reg |-> !produce)
        else $error("second result in one region");
`endif

endmodule

`default_nettype wire

FILE: sv/masked_byte_pattern_search.sv
// Path: a result reaches m_tvalid through the window stage, the queue and the
//   output register, and is held back further under stall.
// Throughput: 1 byte per cycle unless the queue is full; parallel window compare.
// Reset: rst_n clears all control state at once; config resets to length 1,
//   everything else zero. No clearing pass is needed.
`default_nettype none

module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  wire logic                              s_tlast,   // last_byte
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mbps_pkg::CNT_W-1:0]             m_tdata,   // [31:0] match_offset
    output logic                                   m_tuser,   // [0] status
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbps_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]               length_reg, length_next;
    logic [PAT_BYTES-1:0][7:0]      pattern_reg, pattern_next;
    logic [MASK_W-1:0]              mask_reg, mask_next;
    logic                           mode_reg, mode_next;

    logic   push, q_full, q_valid, pop;
    step_t  push_step, q_head;

    // Decode a config write; unknown indexes are dropped
    always_comb
    begin
        length_next  = length_reg;
        pattern_next = pattern_reg;
        mask_next    = mask_reg;
        mode_next    = mode_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LENGTH: length_next         = cfg_data[LEN_W-1:0];
                REG_WORD0:  pattern_next[7:0]   = cfg_data;
                REG_WORD1:  pattern_next[15:8]  = cfg_data;
                REG_WORD2:  pattern_next[23:16] = cfg_data;
                REG_WORD3:  pattern_next[31:24] = cfg_data;
                REG_MASK:   mask_next           = cfg_data[MASK_W-1:0];
                REG_MODE:   mode_next           = cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= LEN_W'(1);
            pattern_reg <= '0;
            mask_reg    <= '0;
            mode_reg    <= MODE_SCAN;
        end
        else
        begin
            length_reg  <= length_next;
            pattern_reg <= pattern_next;
            mask_reg    <= mask_next;
            mode_reg    <= mode_next;
        end
    end

    // Front: shift the byte window, count, compare and classify each byte
    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_byte        (s_tdata),
        .in_last        (s_tlast),
        .pattern_length (length_reg),
        .pattern        (pattern_reg[MAX_PATTERN-1:0]),
        .care           (mask_reg[MAX_PATTERN-1:0]),
        .mode           (mode_reg),
        .push           (push),
        .push_step      (push_step),
        .q_full         (q_full)
    );

    // Short queue: lets the front run on while the result side stalls
    mbps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_step (push_step),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back: track one answer per region and hold the result for transfer
    mbps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_offset (m_tdata)
    );

endmodule

`default_nettype wire
